FILE: sv/gsi_pkg.sv
package gsi_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int PROD_WIDTH = 2 * COUNT_WIDTH;
   localparam int FRAC_BITS = 16;
   localparam int FIX_WIDTH = FRAC_BITS + 1;
   localparam int MAX_CLASSES_DEFAULT = 16;

   localparam logic [FIX_WIDTH-1:0] ONE_FIX = FIX_WIDTH'(1) << FRAC_BITS;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_LSB = 2;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OBJECT_TOTAL = '0;
   localparam logic [COUNT_WIDTH-1:0] OBJECT_TOTAL_RESET = COUNT_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_DIFF,
      ST_GINI_START,
      ST_GINI_WAIT,
      ST_TERM_START,
      ST_TERM_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic {
      DIV_GINI,
      DIV_TERM
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        accum;
      logic        diff;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_gini;
      logic        latch_term;
      logic        emit;
   } dp_cmd_type;

   typedef struct packed {
      logic col_end;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: sv/gsi_req_if.sv
interface gsi_req_if;
   import gsi_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] cell_count;
   logic [COUNT_WIDTH-1:0] column_total;
   logic                   last_in_column;
   logic                   last_in_table;

   modport source (
      output valid, cell_count, column_total, last_in_column, last_in_table,
      input  ready
   );

   modport sink (
      input  valid, cell_count, column_total, last_in_column, last_in_table,
      output ready
   );

endinterface

FILE: sv/gsi_rsp_if.sv
interface gsi_rsp_if;
   import gsi_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FIX_WIDTH-1:0] column_gini;
   logic [FIX_WIDTH-1:0] split_gini;
   logic                 split_done;

   modport source (
      output valid, column_gini, split_gini, split_done,
      input  ready
   );

   modport sink (
      input  valid, column_gini, split_gini, split_done,
      output ready
   );

endinterface

FILE: sv/gsi_divider.sv
module gsi_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gsi_pkg::PROD_WIDTH-1:0] dividend,
   input  logic [gsi_pkg::PROD_WIDTH-1:0] divisor,
   output logic [gsi_pkg::FRAC_BITS-1:0]  quotient,
   output logic                           done
);
   import gsi_pkg::*;

   localparam int CNT_WIDTH = $clog2(FRAC_BITS);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(FRAC_BITS - 1);

   logic [PROD_WIDTH-1:0] rem_ff, rem_in;
   logic [PROD_WIDTH-1:0] divisor_ff, divisor_in;
   logic [FRAC_BITS-1:0]  quot_ff, quot_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [PROD_WIDTH:0]   shifted;
   logic [PROD_WIDTH:0]   reduced;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, divisor_ff};
      reduced = shifted - {1'b0, divisor_ff};
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = dividend;
         divisor_in = divisor;
         quot_in    = '0;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? reduced[PROD_WIDTH-1:0] : shifted[PROD_WIDTH-1:0];
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

FILE: sv/gsi_datapath.sv
module gsi_datapath #(
   parameter int MAX_CLASSES = gsi_pkg::MAX_CLASSES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gsi_pkg::dp_cmd_type             cmd,
   output gsi_pkg::dp_status_type          status,
   input  logic [gsi_pkg::COUNT_WIDTH-1:0] object_total,
   input  logic [gsi_pkg::COUNT_WIDTH-1:0] cell_count,
   input  logic [gsi_pkg::COUNT_WIDTH-1:0] column_total,
   input  logic                            last_in_column,
   input  logic                            last_in_table,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gsi_pkg::FIX_WIDTH-1:0]   column_gini,
   output logic [gsi_pkg::FIX_WIDTH-1:0]   split_gini,
   output logic                            split_done
);
   import gsi_pkg::*;

   localparam int SQ_WIDTH = PROD_WIDTH + $clog2(MAX_CLASSES);
   localparam logic [SQ_WIDTH-1:0] COUNT_MAX = SQ_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic [SQ_WIDTH-1:0] SQUARE_MAX = SQ_WIDTH'(MAX_CLASSES) * COUNT_MAX * COUNT_MAX;

   logic [PROD_WIDTH-1:0]  sq_ff, sq_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   col_end_ff, col_end_in;
   logic                   tab_end_ff, tab_end_in;
   logic [SQ_WIDTH-1:0]    sqsum_ff, sqsum_in;
   logic [PROD_WIDTH-1:0]  tsq_ff, tsq_in;
   logic [PROD_WIDTH-1:0]  diff_ff, diff_in;
   logic [PROD_WIDTH-1:0]  tn_ff, tn_in;
   logic [FIX_WIDTH-1:0]   gini_ff, gini_in;
   logic [FIX_WIDTH-1:0]   term_ff, term_in;
   logic [FIX_WIDTH-1:0]   split_ff, split_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIX_WIDTH-1:0]   rsp_gini_ff, rsp_gini_in;
   logic [FIX_WIDTH-1:0]   rsp_split_ff, rsp_split_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic [SQ_WIDTH:0]      sum_wide;
   logic [FIX_WIDTH:0]     split_wide;
   logic [FIX_WIDTH-1:0]   split_next;
   logic [PROD_WIDTH-1:0]  div_divisor;
   logic [FRAC_BITS-1:0]   div_quotient;
   logic                   div_done;

   assign div_divisor = (cmd.div_sel == DIV_TERM) ? tn_ff : tsq_ff;

   gsi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff_ff),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      sum_wide   = {1'b0, sqsum_ff} + (SQ_WIDTH + 1)'(sq_ff);
      split_wide = {1'b0, split_ff} + {1'b0, term_ff};
      split_next = (split_wide > {1'b0, ONE_FIX}) ? ONE_FIX : split_wide[FIX_WIDTH-1:0];

      sq_in        = sq_ff;
      total_in     = total_ff;
      col_end_in   = col_end_ff;
      tab_end_in   = tab_end_ff;
      sqsum_in     = sqsum_ff;
      tsq_in       = tsq_ff;
      diff_in      = diff_ff;
      tn_in        = tn_ff;
      gini_in      = gini_ff;
      term_in      = term_ff;
      split_in     = split_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_gini_in  = rsp_gini_ff;
      rsp_split_in = rsp_split_ff;
      rsp_done_in  = rsp_done_ff;

      if (cmd.capture) begin
         sq_in      = cell_count * cell_count;
         total_in   = column_total;
         col_end_in = last_in_column;
         tab_end_in = last_in_table;
      end

      if (cmd.accum) begin
         sqsum_in = (sum_wide > {1'b0, SQUARE_MAX}) ? SQUARE_MAX : sum_wide[SQ_WIDTH-1:0];
         tsq_in   = total_ff * total_ff;
      end

      if (cmd.diff) begin
         diff_in  = (sqsum_ff < SQ_WIDTH'(tsq_ff)) ?
                    (tsq_ff - sqsum_ff[PROD_WIDTH-1:0]) : '0;
         tn_in    = total_ff * object_total;
         sqsum_in = '0;
      end

      if (cmd.latch_gini) begin
         if (tsq_ff == '0) begin
            gini_in = '0;
         end else if (diff_ff >= tsq_ff) begin
            gini_in = ONE_FIX;
         end else begin
            gini_in = {1'b0, div_quotient};
         end
      end

      if (cmd.latch_term) begin
         if (tn_ff == '0) begin
            term_in = '0;
         end else if (diff_ff >= tn_ff) begin
            term_in = ONE_FIX;
         end else begin
            term_in = {1'b0, div_quotient};
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_gini_in  = gini_ff;
         rsp_split_in = split_next;
         rsp_done_in  = tab_end_ff;
         split_in     = tab_end_ff ? '0 : split_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqsum_ff     <= '0;
         split_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sqsum_ff     <= sqsum_in;
         split_ff     <= split_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sq_ff        <= sq_in;
      total_ff     <= total_in;
      col_end_ff   <= col_end_in;
      tab_end_ff   <= tab_end_in;
      tsq_ff       <= tsq_in;
      diff_ff      <= diff_in;
      tn_ff        <= tn_in;
      gini_ff      <= gini_in;
      term_ff      <= term_in;
      rsp_gini_ff  <= rsp_gini_in;
      rsp_split_ff <= rsp_split_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign status.col_end  = col_end_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign column_gini = rsp_gini_ff;
   assign split_gini  = rsp_split_ff;
   assign split_done  = rsp_done_ff;

endmodule

FILE: sv/gsi_ctrl.sv
module gsi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output gsi_pkg::dp_cmd_type    cmd,
   input  gsi_pkg::dp_status_type status
);
   import gsi_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = DIV_GINI;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.accum = 1'b1;
            state_in  = status.col_end ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_GINI_START;
         end
         ST_GINI_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_GINI_WAIT;
         end
         ST_GINI_WAIT: begin
            if (status.div_done) begin
               cmd.latch_gini = 1'b1;
               state_in       = ST_TERM_START;
            end
         end
         ST_TERM_START: begin
            cmd.div_sel   = DIV_TERM;
            cmd.div_start = 1'b1;
            state_in      = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            cmd.div_sel = DIV_TERM;
            if (status.div_done) begin
               cmd.latch_term = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/gini_split_impurity_core.sv
// Weighted Gini split of a contingency table in 17-bit fixed point (65536 = 1.0). Class
// counts enter one cell per transaction, column by column; a cell that does not end its
// column passes through capture with the squaring multiplier, then the saturating add.
// A column's last cell waits on both divisions before the next transaction is taken:
// the column index and the weighted term each come from the one shared radix-2 divider,
// 16 quotient bits at one bit a cycle, and the two divisions run back to back. Results
// leave through an output register, so the next column is accepted while a result waits.
// object_total lies at byte address 0 of the APB port and should only be written while
// the block is idle; a zero column total or zero object_total contributes nothing.
module gini_split_impurity_core #(
   parameter int MAX_CLASSES = gsi_pkg::MAX_CLASSES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   gsi_req_if.sink                            req_chan,
   gsi_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gsi_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [gsi_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [gsi_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import gsi_pkg::*;

   logic [COUNT_WIDTH-1:0]     object_total_ff, object_total_in;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                       csr_write;
   logic                       req_ready;
   dp_cmd_type                 cmd;
   dp_status_type              status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      object_total_in = object_total_ff;
      if (csr_write && (csr_index == REG_OBJECT_TOTAL)) begin
         object_total_in = csr_pwdata[COUNT_WIDTH-1:0];
      end
      csr_prdata = '0;
      if (csr_index == REG_OBJECT_TOTAL) begin
         csr_prdata = CSR_DATA_WIDTH'(object_total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         object_total_ff <= OBJECT_TOTAL_RESET;
      end else begin
         object_total_ff <= object_total_in;
      end
   end

   assign req_chan.ready = req_ready;

   gsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   gsi_datapath #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .object_total   (object_total_ff),
      .cell_count     (req_chan.cell_count),
      .column_total   (req_chan.column_total),
      .last_in_column (req_chan.last_in_column),
      .last_in_table  (req_chan.last_in_table),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .column_gini    (rsp_chan.column_gini),
      .split_gini     (rsp_chan.split_gini),
      .split_done     (rsp_chan.split_done)
   );

endmodule

FILE: sim/gini_split_impurity_core_tb.sv
module gini_split_impurity_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gsi_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_CELLS = 132;
   localparam logic [35:0] SQUARE_CAP =
      36'(MAX_CLASSES_DEFAULT) * 36'(16'hFFFF) * 36'(16'hFFFF);
   localparam logic [FIX_WIDTH-1:0] SPLIT_CAP = ONE_FIX;

   typedef struct packed {
      logic [FIX_WIDTH-1:0] column_gini;
      logic [FIX_WIDTH-1:0] split_gini;
      logic                 split_done;
   } column_result_t;

   class gini_tally;
      logic [COUNT_WIDTH-1:0] object_total;
      logic [35:0]            square_sum;
      logic [FIX_WIDTH-1:0]   split_sum;
      column_result_t         expected_columns[$];
      int                     fail_count;
      int                     cells_noted;
      int                     columns_checked;
      int                     tables_done;

      function new();
         object_total = OBJECT_TOTAL_RESET;
         square_sum = '0;
         split_sum = '0;
         fail_count = 0;
         cells_noted = 0;
         columns_checked = 0;
         tables_done = 0;
      endfunction

      function int pending();
         return expected_columns.size();
      endfunction

      function void note_cell(logic [COUNT_WIDTH-1:0] count, logic [COUNT_WIDTH-1:0] total,
                              logic col_end, logic tab_end);
         logic [63:0]    acc;
         logic [63:0]    tsq;
         logic [63:0]    diff;
         logic [63:0]    gini;
         logic [63:0]    term;
         column_result_t r;
         cells_noted++;
         acc = 64'(square_sum) + 64'(count) * 64'(count);
         if (acc > 64'(SQUARE_CAP)) acc = 64'(SQUARE_CAP);
         square_sum = acc[35:0];
         if (!col_end) return;
         tsq = 64'(total) * 64'(total);
         diff = (64'(square_sum) < tsq) ? tsq - 64'(square_sum) : 64'd0;
         gini = '0;
         term = '0;
         if (total != 0) begin
            gini = (diff << FRAC_BITS) / tsq;
            if (object_total != 0) term = (diff << FRAC_BITS) / (64'(total) * 64'(object_total));
         end
         acc = 64'(split_sum) + term;
         if (acc > 64'(SPLIT_CAP)) acc = 64'(SPLIT_CAP);
         split_sum = acc[FIX_WIDTH-1:0];
         r.column_gini = gini[FIX_WIDTH-1:0];
         r.split_gini = split_sum;
         r.split_done = tab_end;
         expected_columns.push_back(r);
         square_sum = '0;
         if (tab_end) split_sum = '0;
      endfunction

      function void check_column(logic [FIX_WIDTH-1:0] column_gini,
                                 logic [FIX_WIDTH-1:0] split_gini, logic split_done);
         column_result_t r;
         if (expected_columns.size() == 0) begin
            $display("%0t: unexpected transaction column_gini=%0d split_gini=%0d split_done=%0b",
                     $time, column_gini, split_gini, split_done);
            fail_count++;
            return;
         end
         r = expected_columns.pop_front();
         columns_checked++;
         if (r.split_done) tables_done++;
         if (column_gini !== r.column_gini) begin
            $display("%0t: column_gini expected %0d actual %0d", $time, r.column_gini,
                     column_gini);
            fail_count++;
         end
         if (split_gini !== r.split_gini) begin
            $display("%0t: split_gini expected %0d actual %0d", $time, r.split_gini, split_gini);
            fail_count++;
         end
         if (split_done !== r.split_done) begin
            $display("%0t: split_done expected %0b actual %0b", $time, r.split_done, split_done);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   gsi_req_if req_if ();
   gsi_rsp_if rsp_if ();

   gini_tally tally = new();
   bit        calm = 1'b0;
   int        rsp_hold = 0;
   int        cycle_count = 0;
   int        settings_used = 0;

   gini_split_impurity_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 15));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            tally.check_column(rsp_if.column_gini, rsp_if.split_gini, rsp_if.split_done);
            rsp_hold = draw_wait();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_if.ready <= (rsp_hold == 0);
      end
   end

   task automatic csr_transfer(logic write, logic [CSR_DATA_WIDTH-1:0] data,
                               output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_ADDR_WIDTH'(REG_OBJECT_TOTAL) << CSR_INDEX_LSB;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_object_total(logic [COUNT_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] rdata;
      csr_transfer(1'b1, {16'($urandom_range(0, 65535)), value}, rdata);
      tally.object_total = value;
      settings_used++;
      @(posedge clock);
      csr_transfer(1'b0, '0, rdata);
      if (rdata[COUNT_WIDTH-1:0] !== value) begin
         $display("%0t: object_total read back expected %0d actual %0d", $time, value,
                  rdata[COUNT_WIDTH-1:0]);
         tally.fail_count++;
      end
   endtask

   task automatic send_cell(logic [COUNT_WIDTH-1:0] count, logic [COUNT_WIDTH-1:0] total,
                            logic col_end, logic tab_end);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cell_count <= count;
      req_if.column_total <= total;
      req_if.last_in_column <= col_end;
      req_if.last_in_table <= tab_end;
      do @(posedge clock); while (!req_if.ready);
      tally.note_cell(count, total, col_end, tab_end);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (tally.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_table();
      int                     n_cols;
      int                     n_cells;
      int                     cmax;
      int                     sum;
      int                     counts[$];
      logic [COUNT_WIDTH-1:0] total;
      logic [COUNT_WIDTH-1:0] cell_total;
      logic                   is_last_col;
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
         0: cmax = 15;
         1: cmax = 255;
         2: cmax = 4095;
         default: cmax = 65535;
      endcase
      n_cols = $urandom_range(1, 5);
      for (int c = 0; c < n_cols; c++) begin
         counts.delete();
         sum = 0;
         n_cells = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 6);
         for (int k = 0; k < n_cells; k++) begin
            case ($urandom_range(0, 9))
               0: counts.push_back(0);
               1: counts.push_back(cmax);
               default: counts.push_back($urandom_range(0, cmax));
            endcase
            sum += counts[k];
         end
         case ($urandom_range(0, 15))
            0: total = '0;
            1, 2: total = 16'($urandom_range(0, 65535));
            default: total = (sum > 65535) ? 16'hFFFF : 16'(sum);
         endcase
         is_last_col = (c == n_cols - 1);
         for (int k = 0; k < n_cells; k++) begin
            cell_total = (k == n_cells - 1 || $urandom_range(0, 7) != 0) ?
                         total : 16'($urandom_range(0, 65535));
            send_cell(16'(counts[k]), cell_total, k == n_cells - 1,
                      is_last_col || $urandom_range(0, 9) == 0);
         end
      end
   endtask

   initial begin
      logic [COUNT_WIDTH-1:0] n;
      int                     phase_start;
      req_if.valid = 1'b0;
      req_if.cell_count = '0;
      req_if.column_total = '0;
      req_if.last_in_column = 1'b0;
      req_if.last_in_table = 1'b0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cell(16'd0, 16'd0, 1'b1, 1'b1);
      send_cell(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      send_cell(16'd0, 16'hFFFF, 1'b1, 1'b0);
      send_cell(16'hFFFF, 16'd1, 1'b1, 1'b0);
      send_cell(16'd1, 16'd2, 1'b0, 1'b0);
      send_cell(16'd1, 16'd2, 1'b1, 1'b1);
      send_cell(16'd5, 16'd9, 1'b0, 1'b1);
      repeat (MAX_CLASSES_DEFAULT) send_cell(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      send_cell(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      settle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: n = '0;
            1: n = 16'hFFFF;
            2: n = 16'd1;
            3: n = 16'($urandom_range(2, 64));
            4: n = 16'($urandom_range(64, 4096));
            7: n = 16'hFFFF;
            default: n = 16'($urandom_range(0, 65535));
         endcase
         set_object_total(n);
         phase_start = tally.cells_noted;
         while (tally.cells_noted - phase_start < PHASE_CELLS) begin
            if ($urandom_range(0, 9) == 0) begin
               calm = 1'b0;
               send_cell(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               run_table();
            end
         end
         send_cell(16'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'b1, 1'b1);
         settle();
      end

      $display("Sent %0d cells over %0d object_total settings, zero and full scale included.",
               tally.cells_noted, settings_used);
      $display("Checked %0d column results, %0d of them closing a split.",
               tally.columns_checked, tally.tables_done);
      if (tally.fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/gsi_pkg.sv
sv/gsi_req_if.sv
sv/gsi_rsp_if.sv
sv/gsi_divider.sv
sv/gsi_datapath.sv
sv/gsi_ctrl.sv
sv/gini_split_impurity_core.sv
sim/gini_split_impurity_core_tb.sv
